FILE: sv/bcs_pkg.sv
// ----------------------------------------------------------------------------
// Bezier curve sampler package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bcs_pkg;

   localparam int COORD_W    = 32;
   localparam int NUM_AXES   = 3;
   localparam int FRAC_W     = 16;
   localparam int T_W        = 17;
   localparam int RES_W      = 6;
   localparam int PC_W       = 5;
   localparam int IDX_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int DIV_CNT_W  = 5;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd17;
   localparam logic [T_W-1:0]       T_ONE     = 17'h10000;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_GENERATE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESOLUTION  = 1'd1;

   localparam logic [PC_W-1:0]  POINT_COUNT_RESET = 5'd4;
   localparam logic [RES_W-1:0] RESOLUTION_RESET  = 6'd16;

   typedef logic [NUM_AXES-1:0][COORD_W-1:0] point_type;

   typedef struct packed {
      logic             load;
      logic             gen_start;
      logic             div_run;
      logic             rd_ctrl;
      logic             cap_a;
      logic             single;
      logic             mul;
      logic             add_wr;
      logic             emit;
      logic [RES_W-1:0] res;
      logic [RES_W-1:0] index;
      logic             last;
   } bcs_cmd_type;

   typedef struct packed {
      logic div_done;
   } bcs_sts_type;

endpackage

FILE: sv/bcs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bcs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bcs_ctrl.sv
// ----------------------------------------------------------------------------
// Bezier curve sampler controller
// Sequences the parameter divider, the de Casteljau rounds and the sample
// transfers; drives store addresses and datapath commands.
// ----------------------------------------------------------------------------
module bcs_ctrl
   import bcs_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   localparam int AW = $clog2(MAX_POINTS),
   localparam int CW = $clog2(MAX_POINTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_cmd,
   input  logic [CW-1:0]     point_count_eff,
   input  logic [RES_W-1:0]  resolution_eff,
   input  bcs_sts_type       sts,
   output logic              busy,
   output bcs_cmd_type       cmd,
   output logic [AW-1:0]     rd_addr,
   output logic [AW-1:0]     wr_addr
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_RD_A  = 3'd2;
   localparam logic [2:0] S_GET_A = 3'd3;
   localparam logic [2:0] S_GET_B = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [CW-1:0]    r_ff, r_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic [RES_W-1:0] i_ff, i_in;
   logic             more_lerps;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      res_in   = res_ff;
      i_in     = i_ff;
      cmd         = '0;
      cmd.res     = res_ff;
      cmd.index   = i_ff;
      cmd.last    = (i_ff == res_ff);
      cmd.rd_ctrl = (r_ff == CW'(1));
      rd_addr  = '0;
      wr_addr  = k_ff;
      busy     = (state_ff != S_IDLE);
      more_lerps = ((CW'(k_ff) + CW'(1)) < (n_ff - r_ff));
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.gen_start = 1'b1;
                  n_in     = point_count_eff;
                  res_in   = resolution_eff;
                  i_in     = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_run = 1'b1;
            if (sts.div_done) begin
               r_in     = CW'(1);
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            state_in = S_GET_A;
         end
         S_GET_A: begin
            cmd.cap_a = 1'b1;
            rd_addr   = AW'(1);
            k_in      = '0;
            if (n_ff == CW'(1)) begin
               cmd.single = 1'b1;
               state_in   = S_EMIT;
            end else begin
               state_in = S_GET_B;
            end
         end
         S_GET_B: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add_wr = 1'b1;
            if (more_lerps) begin
               rd_addr  = AW'(k_ff + AW'(2));
               k_in     = AW'(k_ff + AW'(1));
               state_in = S_GET_B;
            end else if ((r_ff + CW'(1)) == n_ff) begin
               state_in = S_EMIT;
            end else begin
               r_in     = r_ff + CW'(1);
               state_in = S_RD_A;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (i_ff == res_ff) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + RES_W'(1);
               r_in     = CW'(1);
               state_in = S_RD_A;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      res_ff <= res_in;
      i_ff   <= i_in;
   end

`ifndef SYNTHESIS
   a_lerp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |-> ((CW'(k_ff) + r_ff) < n_ff))
      else $error("lerp index beyond active round");
`endif

endmodule

FILE: sv/bcs_datapath.sv
// ----------------------------------------------------------------------------
// Bezier curve sampler datapath
// Control point and scratch stores, parameter divider and stepper, three
// lerp lanes and the result register.
// ----------------------------------------------------------------------------
module bcs_datapath
   import bcs_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   localparam int AW = $clog2(MAX_POINTS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bcs_cmd_type               cmd,
   input  logic [AW-1:0]             rd_addr,
   input  logic [AW-1:0]             wr_addr,
   output bcs_sts_type               sts,
   input  logic [IDX_W-1:0]          req_point_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [RES_W-1:0]          rsp_sample_index,
   output logic                      rsp_last
);

   point_type ld_point;
   point_type ctrl_rd, work_rd, rd_data;
   point_type lerp_res;
   point_type a_ff, b_ff, prod_ff, sum_ff, out_ff;
   logic      ld_en;

   logic signed [COORD_W:0]       diff     [NUM_AXES];
   logic signed [COORD_W+T_W+1:0] mul_full [NUM_AXES];

   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [RES_W-1:0]     div_rem_ff;
   logic [T_W-1:0]       div_q_ff;
   logic [RES_W:0]       div_trial;
   logic                 div_ge;
   logic [T_W-1:0]       t_ff;
   logic [RES_W-1:0]     t_rem_ff;
   logic [RES_W:0]       t_rem_sum;
   logic                 t_wrap;

   logic                 rsp_valid_ff;
   logic [RES_W-1:0]     idx_ff;
   logic                 last_ff;

   assign ld_en       = cmd.load && (int'(req_point_index) < MAX_POINTS);
   assign ld_point[0] = req_coord_x;
   assign ld_point[1] = req_coord_y;
   assign ld_point[2] = req_coord_z;

   bcs_ram #(
      .WIDTH (NUM_AXES * COORD_W),
      .DEPTH (MAX_POINTS)
   ) u_ctrl_ram (
      .clock   (clock),
      .wr_en   (ld_en),
      .wr_addr (AW'(req_point_index)),
      .wr_data (ld_point),
      .rd_addr (rd_addr),
      .rd_data (ctrl_rd)
   );

   bcs_ram #(
      .WIDTH (NUM_AXES * COORD_W),
      .DEPTH (MAX_POINTS)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (cmd.add_wr),
      .wr_addr (wr_addr),
      .wr_data (lerp_res),
      .rd_addr (rd_addr),
      .rd_data (work_rd)
   );

   assign rd_data      = cmd.rd_ctrl ? ctrl_rd : work_rd;
   assign sts.div_done = (div_cnt_ff == DIV_STEPS);

   always_comb begin
      div_trial = {div_rem_ff, (div_cnt_ff == '0)};
      div_ge    = (div_trial >= {1'b0, cmd.res});
      t_rem_sum = {1'b0, t_rem_ff} + {1'b0, div_rem_ff};
      t_wrap    = (t_rem_sum >= {1'b0, cmd.res});
      for (int j = 0; j < NUM_AXES; j++) begin
         diff[j]     = $signed({rd_data[j][COORD_W-1], rd_data[j]})
                       - $signed({a_ff[j][COORD_W-1], a_ff[j]});
         mul_full[j] = diff[j] * $signed({1'b0, t_ff});
         lerp_res[j] = a_ff[j] + prod_ff[j];
      end
   end

   // restoring divide of 1.0 by the resolution, then step t by its quotient plus the carry of the accumulated remainder
   always_ff @(posedge clock) begin
      if (cmd.gen_start) begin
         div_cnt_ff <= '0;
         div_rem_ff <= '0;
         div_q_ff   <= '0;
         t_ff       <= '0;
         t_rem_ff   <= '0;
      end else if (cmd.div_run && !sts.div_done) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         div_rem_ff <= div_ge ? RES_W'(div_trial - {1'b0, cmd.res})
                              : div_trial[RES_W-1:0];
         div_q_ff   <= {div_q_ff[T_W-2:0], div_ge};
      end else if (cmd.emit) begin
         t_ff     <= t_ff + div_q_ff + T_W'(t_wrap);
         t_rem_ff <= t_wrap ? RES_W'(t_rem_sum - {1'b0, cmd.res})
                            : t_rem_sum[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         a_ff <= rd_data;
         if (cmd.single) begin
            sum_ff <= rd_data;
         end
      end
      if (cmd.mul) begin
         b_ff <= rd_data;
         for (int j = 0; j < NUM_AXES; j++) begin
            prod_ff[j] <= mul_full[j][COORD_W+FRAC_W-1:FRAC_W];
         end
      end
      if (cmd.add_wr) begin
         a_ff   <= b_ff;
         sum_ff <= lerp_res;
      end
      if (cmd.emit) begin
         out_ff  <= sum_ff;
         idx_ff  <= cmd.index;
         last_ff <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_sample_index = idx_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_t_first_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.index == '0)) |-> (t_ff == '0))
      else $error("first sample parameter not zero");

   a_t_last_one: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |-> (t_ff == T_ONE))
      else $error("last sample parameter not one");
`endif

endmodule

FILE: sv/bezier_curve_sampler.sv
// Load: no result; busy stays low, so loads transfer back to back.
// Generate: a parameter divide, then per sample the de Casteljau rounds,
// one lerp at a time, each written back to the scratch store.
// Each sample moves from the sum register through the result register to the ports.
// Results cannot be stalled. Synchronous reset clears control state and sets
// point_count to 4 and resolution to 16; the point stores stay undefined.
// ----------------------------------------------------------------------------
// Bezier curve sampler
// De Casteljau evaluation of a stored 3D control polygon at evenly spaced
// parameters, signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
module bezier_curve_sampler
   import bcs_pkg::*;
#(
   parameter int MAX_POINTS     = 16,
   parameter int MAX_RESOLUTION = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_cmd,
   input  logic [IDX_W-1:0]          req_point_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [RES_W-1:0]          rsp_sample_index,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [PC_W-1:0]  point_count_ff;
   logic [RES_W-1:0] resolution_ff;
   logic [CW-1:0]    point_count_eff;
   logic [RES_W-1:0] resolution_eff;
   bcs_cmd_type      cmd;
   bcs_sts_type      sts;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RESET;
         resolution_ff  <= RESOLUTION_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_ff <= csr_wr_data[PC_W-1:0];
            CSR_RESOLUTION:  resolution_ff  <= csr_wr_data[RES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp to the supported range
   always_comb begin
      if (point_count_ff == '0) begin
         point_count_eff = CW'(1);
      end else if (int'(point_count_ff) > MAX_POINTS) begin
         point_count_eff = CW'(MAX_POINTS);
      end else begin
         point_count_eff = CW'(point_count_ff);
      end
      if (resolution_ff == '0) begin
         resolution_eff = RES_W'(1);
      end else if (int'(resolution_ff) > MAX_RESOLUTION) begin
         resolution_eff = RES_W'(MAX_RESOLUTION);
      end else begin
         resolution_eff = resolution_ff;
      end
   end

   bcs_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_cmd         (req_cmd),
      .point_count_eff (point_count_eff),
      .resolution_eff  (resolution_eff),
      .sts             (sts),
      .busy            (busy),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr)
   );

   bcs_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .sts              (sts),
      .req_point_index  (req_point_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .rsp_valid        (rsp_valid),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer without a generate run");
`endif

endmodule

FILE: tb/sv/bezier_curve_sampler_checker.sv
// ----------------------------------------------------------------------------
// Bezier curve sampler checker
// Watches the command, result and register ports. It keeps its own copy of
// the control point store and the registers, and evaluates each accepted
// generate command by de Casteljau in fixed point. Every result transfer is
// compared field by field with the oldest predicted curve sample.
// ----------------------------------------------------------------------------
module bezier_curve_sampler_checker
   import bcs_pkg::*;
#(
   parameter int MAX_POINTS     = 16,
   parameter int MAX_RESOLUTION = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_cmd,
   input  logic [IDX_W-1:0]          req_point_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic                      rsp_valid,
   input  logic signed [COORD_W-1:0] rsp_out_x,
   input  logic signed [COORD_W-1:0] rsp_out_y,
   input  logic signed [COORD_W-1:0] rsp_out_z,
   input  logic [RES_W-1:0]          rsp_sample_index,
   input  logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data,
   output int                        failures,
   output int                        pending
);

   typedef struct packed {
      point_type        pos;
      logic [RES_W-1:0] index;
      logic             last;
   } curve_point_type;

   point_type       ctrl_store [MAX_POINTS];
   logic [PC_W-1:0]  point_count;
   logic [RES_W-1:0] resolution;
   curve_point_type  points_due [$];
   curve_point_type  want;
   int               errors;

   function automatic logic [COORD_W-1:0] lerp_coord(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic [T_W-1:0] t);
      longint base;
      longint span;
      base = a;
      span = longint'(b) - base;
      return COORD_W'(base + ((span * longint'(t)) >>> FRAC_W));
   endfunction

   task automatic evaluate_curve();
      int              n;
      int              res;
      int              t;
      point_type       work [MAX_POINTS];
      curve_point_type point_due;
      n   = (point_count == 0) ? 1 : (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
      res = (resolution == 0) ? 1 : (resolution > MAX_RESOLUTION) ? MAX_RESOLUTION : resolution;
      for (int i = 0; i <= res; i++) begin
         t    = (i << FRAC_W) / res;
         work = ctrl_store;
         for (int r = 1; r < n; r++)
            for (int k = 0; k + r < n; k++)
               for (int axis = 0; axis < NUM_AXES; axis++)
                  work[k][axis] = lerp_coord(work[k][axis], work[k + 1][axis], T_W'(t));
         point_due.pos   = work[0];
         point_due.index = RES_W'(i);
         point_due.last  = (i == res);
         points_due      = {points_due, point_due};
      end
   endtask

   task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                  input logic [COORD_W-1:0] expected);
      errors++;
      if (errors <= 100)
         $display("MISMATCH %s: got %h, expected %h", what, got, expected);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         point_count = POINT_COUNT_RESET;
         resolution  = RESOLUTION_RESET;
         points_due.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POINT_COUNT: point_count = csr_wr_data[PC_W-1:0];
               CSR_RESOLUTION:  resolution  = csr_wr_data[RES_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_cmd == CMD_LOAD) begin
               if (req_point_index < MAX_POINTS)
                  ctrl_store[req_point_index] = {req_coord_z, req_coord_y, req_coord_x};
            end else begin
               evaluate_curve();
            end
         end
         if (rsp_valid) begin
            if (points_due.size() == 0) begin
               report_mismatch("result with no sample due, sample_index",
                               COORD_W'(rsp_sample_index), 'x);
            end else begin
               want = points_due.pop_front();
               if (rsp_out_x !== want.pos[0])
                  report_mismatch("out_x", rsp_out_x, want.pos[0]);
               if (rsp_out_y !== want.pos[1])
                  report_mismatch("out_y", rsp_out_y, want.pos[1]);
               if (rsp_out_z !== want.pos[2])
                  report_mismatch("out_z", rsp_out_z, want.pos[2]);
               if (rsp_sample_index !== want.index)
                  report_mismatch("sample_index", COORD_W'(rsp_sample_index),
                                  COORD_W'(want.index));
               if (rsp_last !== want.last)
                  report_mismatch("last", COORD_W'(rsp_last), COORD_W'(want.last));
            end
         end
      end
      failures <= errors;
      pending  <= points_due.size();
   end

endmodule

FILE: tb/sv/bezier_curve_sampler_test.sv
// ----------------------------------------------------------------------------
// Bezier curve sampler testbench
// Loads control points and requests curve runs, first a directed set of
// extreme coordinates and register settings, then random phases under
// changing sender idling. A checker beside the block predicts every sample.
// ----------------------------------------------------------------------------
module bezier_curve_sampler_test;
   import bcs_pkg::*;

   localparam int MAX_POINTS     = 16;
   localparam int MAX_RESOLUTION = 63;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 32;
   localparam int PHASES         = 9;
   localparam int PHASE_ITEMS    = 40;

   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_cmd;
   logic [IDX_W-1:0]          req_point_index;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic signed [COORD_W-1:0] req_coord_z;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic signed [COORD_W-1:0] rsp_out_z;
   logic [RES_W-1:0]          rsp_sample_index;
   logic                      rsp_last;
   logic                      csr_wr_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wr_data;

   int failures;
   int pending;
   int idle_pct;
   int idle_cycles;
   int loads;
   int generates;
   int results;
   int settings;
   int gen_left;
   bit heavy;

   bezier_curve_sampler #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_RESOLUTION (MAX_RESOLUTION)
   ) dut (.*);

   bezier_curve_sampler_checker #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_RESOLUTION (MAX_RESOLUTION)
   ) curve_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid)
            results <= results + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bezier_curve_sampler verification failed");
            $finish;
         end
      end
   end

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return COORD_W'($urandom_range(0, 131071)) - 32'h0001_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic transfer(input logic cmd, input logic [IDX_W-1:0] slot,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_point_index <= slot;
      req_coord_x     <= x;
      req_coord_y     <= y;
      req_coord_z     <= z;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (cmd == CMD_LOAD)
         loads++;
      else
         generates++;
   endtask

   // hold the sender until every predicted sample has arrived
   task automatic quiesce(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] pc_data,
                             input logic [CSR_DATA_W-1:0] res_data);
      quiesce(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_POINT_COUNT;
      csr_wr_data <= pc_data;
      @(posedge clock);
      csr_index   <= CSR_RESOLUTION;
      csr_wr_data <= res_data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings++;
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_LOAD;
      req_point_index = '0;
      req_coord_x     = '0;
      req_coord_y     = '0;
      req_coord_z     = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_POINT_COUNT;
      csr_wr_data     = '0;
      idle_pct        = 24;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot, extremes first
      transfer(CMD_LOAD, 4'd0, COORD_MAX, COORD_MIN, '0);
      transfer(CMD_LOAD, 4'd1, COORD_MIN, COORD_MAX, '1);
      transfer(CMD_LOAD, 4'd2, COORD_MAX, COORD_MAX, COORD_MAX);
      transfer(CMD_LOAD, 4'd3, COORD_MIN, COORD_MIN, COORD_MIN);
      for (int s = 4; s < MAX_POINTS; s++)
         transfer(CMD_LOAD, IDX_W'(s), pick_coord(), pick_coord(), pick_coord());
      transfer(CMD_GENERATE, '1, pick_coord(), pick_coord(), pick_coord());
      set_config(6'd0, 6'd0);
      transfer(CMD_GENERATE, '0, pick_coord(), pick_coord(), pick_coord());
      set_config(6'h3f, 6'd63);
      transfer(CMD_GENERATE, '1, pick_coord(), pick_coord(), pick_coord());
      set_config(6'd16, 6'd1);
      transfer(CMD_GENERATE, '0, pick_coord(), pick_coord(), pick_coord());
      set_config(6'd1, 6'd63);
      transfer(CMD_GENERATE, '1, pick_coord(), pick_coord(), pick_coord());
      set_config(6'h22, 6'd32);
      transfer(CMD_GENERATE, '0, pick_coord(), pick_coord(), pick_coord());

      for (int phase = 0; phase < PHASES; phase++) begin
         idle_pct = (phase < 3) ? 24 : (phase < 6) ? 87 : 0;
         heavy    = (phase % 3 == 1);
         if (heavy)
            set_config(CSR_DATA_W'(16 + $urandom_range(0, 15)), 6'd63);
         else
            set_config(CSR_DATA_W'(($urandom_range(0, 1) << 5) | $urandom_range(0, 7)),
                       CSR_DATA_W'($urandom_range(0, 15)));
         gen_left = heavy ? 2 : PHASE_ITEMS;
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (item == PHASE_ITEMS / 2)
               quiesce(0);
            if (gen_left > 0 && $urandom_range(0, 3) == 0) begin
               gen_left--;
               transfer(CMD_GENERATE, IDX_W'($urandom_range(0, 15)), pick_coord(),
                        pick_coord(), pick_coord());
            end else begin
               transfer(CMD_LOAD, IDX_W'($urandom_range(0, 15)), pick_coord(),
                        pick_coord(), pick_coord());
            end
         end
      end

      quiesce(DRAIN_CYCLES);
      $display("Covered %0d loads and %0d curve runs, %0d samples compared",
               loads, generates, results);
      $display("Applied %0d register settings, zero and saturating values among them",
               settings);
      if (failures == 0 && pending == 0)
         $display("bezier_curve_sampler verification clean");
      else
         $display("bezier_curve_sampler verification failed");
      $finish;
   end

endmodule
